// File: hdl/ersm_pkg.sv
package ersm_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int ELEM_BITS  = 16;
  localparam int TRIG_W     = 19;   // signed Q16, magnitude up to about 65537
  localparam int SIN_A      = 102944;
  localparam int SIN_B      = 42047;
  localparam int SIN_C      = 4640;

  typedef struct packed {
    logic [15:0]        angle_x;
    logic [15:0]        angle_y;
    logic [15:0]        angle_z;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
  } ersm_in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [15:0] col0;
    logic signed [15:0] col1;
    logic signed [15:0] col2;
    logic signed [15:0] col3;
    logic               last_row;
  } ersm_out_t;

  // Reduce an angle to its unsigned Q1.16 fraction within the quadrant (mirrored on odd quadrants).
  function automatic logic [16:0] angle_frac(input logic [ANGLE_BITS-1:0] a);
    logic [16:0] x;
    logic [ANGLE_BITS-3:0] f;
    begin
      f = a[ANGLE_BITS-3:0];
      if (ANGLE_BITS <= 18) x = 17'(f) << (18 - ANGLE_BITS);
      else x = 17'(f >> (ANGLE_BITS - 18));
      if (a[ANGLE_BITS-2]) x = 17'(65536) - x;
      return x;
    end
  endfunction

  // Saturate and keep the low 16 bits.
  function automatic logic [15:0] sat_elem(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    logic signed [47:0] r;
    begin
      hi = (48'sd1 <<< (ELEM_BITS - 1)) - 48'sd1;
      lo = -hi - 48'sd1;
      r = (v > hi) ? hi : ((v < lo) ? lo : v);
      return r[15:0];
    end
  endfunction

endpackage

// File: hdl/ersm_sine.sv
module ersm_sine (
  input  logic                              clk,
  input  logic                              en,
  input  logic [ersm_pkg::ANGLE_BITS-1:0]   angle,
  output logic signed [ersm_pkg::TRIG_W-1:0] sine
);
  import ersm_pkg::*;

  // Four register stages: x2, C term, B term, A term; sign applied at the end.
  logic [16:0] xa;
  logic [16:0] x1_r, x2q_r, x3_r;
  logic [16:0] sq1_r, sq2_r;
  logic [1:0]  s1_r, s2_r, s3_r, s4_r;
  logic [17:0] t2_r, t3_r;
  logic [17:0] t4_r;
  logic [33:0] p_sq;
  logic [34:0] p_c, p_b, p_a;
  logic [17:0] tb, ta;

  assign xa   = angle_frac(angle);
  assign p_sq = 34'(xa) * 34'(xa);
  assign p_c  = 35'(SIN_C) * 35'(sq1_r);
  assign tb   = 18'(SIN_B) - 18'(p_c >> 16);
  assign p_b  = 35'(t2_r) * 35'(sq2_r);
  assign ta   = 18'(SIN_A) - 18'(p_b >> 16);
  assign p_a  = 35'(t3_r) * 35'(x3_r);

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r  <= xa;
      s1_r  <= angle[ANGLE_BITS-1 -: 2];
      sq1_r <= 17'(p_sq >> 16);
      x2q_r <= x1_r;
      s2_r  <= s1_r;
      sq2_r <= sq1_r;
      t2_r  <= tb;
      x3_r  <= x2q_r;
      s3_r  <= s2_r;
      t3_r  <= ta;
      t4_r  <= 18'(p_a >> 16);
      s4_r  <= s3_r;
    end
  end

  assign sine = s4_r[1] ? -$signed({1'b0, t4_r}) : $signed({1'b0, t4_r});
endmodule

// File: hdl/euler_rotation_scale_matrix.sv
// Euler rotation/scale matrix unit: each input beat (three angles, fractions
// of a full turn, and three Q3.12 scales) yields the four rows of
// M = Rx*Ry*Rz*S as four output beats, row 0 first, last_row high on row 3.
// Elements are Q3.12 and saturate. The pipeline is eight stages deep
// (four for the sine polynomial, two for the triple products, two for
// scaling); the single result port sends one row per accepted beat; new
// items enter until one waits in the last stage while the row buffer is busy.
// The whole pipe advances only when it may; a stall holds every stage.
module euler_rotation_scale_matrix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ersm_pkg::ersm_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ersm_pkg::ersm_out_t out_data
);
  import ersm_pkg::*;

  localparam int DEPTH = 8;
  localparam int QTR   = 1 << (ANGLE_BITS - 2);

  logic adv;
  logic [DEPTH-1:0] v_r;
  logic signed [TRIG_W-1:0] sx, cx, sy, cy, sz, cz;
  logic signed [15:0] scx_r [4], scy_r [4], scz_r [4];

  // Row buffer: holds one finished matrix and walks its rows out.
  logic        buf_v_r;
  logic [1:0]  row_r;
  logic [15:0] m_r [3][3];
  logic        drain;

  assign drain = buf_v_r && out_ready && (row_r == 2'd3);
  assign adv = !(v_r[DEPTH-1] && buf_v_r && !drain);
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[DEPTH-2:0], in_valid};
  end

  ersm_sine u_sx (.clk, .en(adv), .angle(in_data.angle_x[ANGLE_BITS-1:0]), .sine(sx));
  ersm_sine u_cx (.clk, .en(adv),
    .angle(ANGLE_BITS'(in_data.angle_x[ANGLE_BITS-1:0] + ANGLE_BITS'(QTR))), .sine(cx));
  ersm_sine u_sy (.clk, .en(adv), .angle(in_data.angle_y[ANGLE_BITS-1:0]), .sine(sy));
  ersm_sine u_cy (.clk, .en(adv),
    .angle(ANGLE_BITS'(in_data.angle_y[ANGLE_BITS-1:0] + ANGLE_BITS'(QTR))), .sine(cy));
  ersm_sine u_sz (.clk, .en(adv), .angle(in_data.angle_z[ANGLE_BITS-1:0]), .sine(sz));
  ersm_sine u_cz (.clk, .en(adv),
    .angle(ANGLE_BITS'(in_data.angle_z[ANGLE_BITS-1:0] + ANGLE_BITS'(QTR))), .sine(cz));

  // Carry scales alongside the trig pipe.
  always_ff @(posedge clk) begin
    if (adv) begin
      scx_r[0] <= in_data.scale_x; scy_r[0] <= in_data.scale_y; scz_r[0] <= in_data.scale_z;
      for (int i = 1; i < 4; i++) begin
        scx_r[i] <= scx_r[i-1]; scy_r[i] <= scy_r[i-1]; scz_r[i] <= scz_r[i-1];
      end
    end
  end

  // Stage 5: pairwise Q32 products.
  logic signed [37:0] cycz_r, cysz_r, sxsy_r, cxsz_r, cxcz_r, sxcy_r, sxsz_r, cxsy_r;
  logic signed [37:0] sxcz_r, cxcy_r;
  logic signed [TRIG_W-1:0] sy5_r, cz5_r, sz5_r;
  logic signed [15:0] sc5_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      cycz_r <= cy * cz; cysz_r <= cy * sz; sxsy_r <= sx * sy; cxsz_r <= cx * sz;
      cxcz_r <= cx * cz; sxcy_r <= sx * cy; sxsz_r <= sx * sz; cxsy_r <= cx * sy;
      sxcz_r <= sx * cz; cxcy_r <= cx * cy;
      sy5_r <= sy; cz5_r <= cz; sz5_r <= sz;
      sc5_r[0] <= scx_r[3]; sc5_r[1] <= scy_r[3]; sc5_r[2] <= scz_r[3];
    end
  end

  // Stage 6: Q48 sums, rounded to Q16.
  logic signed [63:0] q48 [3][3];
  logic signed [31:0] rot_r [3][3];
  logic signed [15:0] sc6_r [3];
  always_comb begin
    q48[0][0] = 64'(cycz_r) <<< 16;
    q48[0][1] = -(64'(cysz_r) <<< 16);
    q48[0][2] = 64'(sy5_r) <<< 32;
    q48[1][0] = 64'(sxsy_r) * 64'(cz5_r) + (64'(cxsz_r) <<< 16);
    q48[1][1] = (64'(cxcz_r) <<< 16) - 64'(sxsy_r) * 64'(sz5_r);
    q48[1][2] = -(64'(sxcy_r) <<< 16);
    q48[2][0] = (64'(sxsz_r) <<< 16) - 64'(cxsy_r) * 64'(cz5_r);
    q48[2][1] = 64'(cxsy_r) * 64'(sz5_r) + (64'(sxcz_r) <<< 16);
    q48[2][2] = 64'(cxcy_r) <<< 16;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          rot_r[r][c] <= 32'((q48[r][c] + 64'sd2147483648) >>> 32);
      sc6_r <= sc5_r;
    end
  end

  // Stage 7: scale products (Q28).
  logic signed [47:0] prod_r [3][3];
  always_ff @(posedge clk) begin
    if (adv)
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          prod_r[r][c] <= 48'(rot_r[r][c]) * 48'(sc6_r[c]);
  end

  // Stage 8: round to Q12 and saturate.
  logic [15:0] el_r [3][3];
  always_ff @(posedge clk) begin
    if (adv)
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          el_r[r][c] <= sat_elem((prod_r[r][c] + 48'sd32768) >>> 16);
  end

  // Load the row buffer when it is empty or emptying; drop rows one per beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_v_r <= 1'b0;
      row_r   <= 2'd0;
    end else if (adv && v_r[DEPTH-1]) begin
      buf_v_r <= 1'b1;
      row_r   <= 2'd0;
    end else begin
      if (buf_v_r && out_ready) row_r <= row_r + 2'd1;
      if (drain) buf_v_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (adv && v_r[DEPTH-1]) m_r <= el_r;
  end

  logic [15:0] one_q12;
  assign one_q12 = sat_elem(48'sd4096);

  always_comb begin
    out_valid = buf_v_r;
    out_data.row_index = row_r;
    out_data.last_row  = (row_r == 2'd3);
    if (row_r == 2'd3) begin
      out_data.col0 = '0; out_data.col1 = '0; out_data.col2 = '0;
      out_data.col3 = one_q12;
    end else begin
      out_data.col0 = m_r[row_r][0];
      out_data.col1 = m_r[row_r][1];
      out_data.col2 = m_r[row_r][2];
      out_data.col3 = '0;
    end
  end
endmodule
